// ===== hw/rtl/blg_pkg.sv =====
package blg_pkg;

   localparam int unsigned CFG_BITS     = 12;
   localparam int unsigned HOLDOFF_BITS = 7;
   localparam int unsigned LEVEL_BITS   = 7;
   localparam int unsigned CHG_BITS     = 2;
   localparam int unsigned PINS_BITS    = 12;
   localparam int unsigned CSR_IDX_BITS = 2;

   // register map
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMPTY_LEVEL       = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_LEVEL        = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_FULL_LEVEL = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISPLAY_HOLDOFF   = 2'd3;

   localparam logic [CFG_BITS-1:0]     EMPTY_LEVEL_RST       = 12'd2048;
   localparam logic [CFG_BITS-1:0]     FULL_LEVEL_RST        = 12'd3072;
   localparam logic [CFG_BITS-1:0]     CHARGE_FULL_LEVEL_RST = 12'd3200;
   localparam logic [HOLDOFF_BITS-1:0] DISPLAY_HOLDOFF_RST   = 7'd100;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO       = 7'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL       = 7'd100;
   localparam logic [LEVEL_BITS-1:0] LEVEL_NO_BATTERY = 7'd120;

   localparam logic [CFG_BITS-1:0] AVG_DIVISOR = 12'd3;

   localparam logic [CHG_BITS-1:0] CHG_CHARGING = 2'd0;
   localparam logic [CHG_BITS-1:0] CHG_DONE     = 2'd1;
   localparam logic [CHG_BITS-1:0] CHG_ERROR    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LATCH,
      ST_LOAD,
      ST_PCT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;       // take the request, keep the sample sum
      logic step;       // one divider iteration
      logic latch_avg;  // keep the average (sum / 3 by reciprocal multiply)
      logic load_pct;   // scaled difference / span into the divider
      logic commit;     // result into the output register, update display state
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

   function automatic logic [CHG_BITS-1:0] classify_pins(input logic [PINS_BITS-1:0] pins);
      logic steady0;
      logic steady1;
      steady0 = (pins[3:0] == 4'h0) || (pins[3:0] == 4'hF);
      steady1 = (pins[7:4] == 4'h0) || (pins[7:4] == 4'hF);
      // the third round only contributes its first sample
      if (!steady0 || !steady1) begin
         return CHG_ERROR;
      end
      return pins[8] ? CHG_DONE : CHG_CHARGING;
   endfunction

endpackage

// ===== hw/rtl/battery_level_gauge_unit.sv =====
// channel  direction  handshake           payload
// req      in         req_valid/req_stall  3 battery samples, adapter, charger pins, display enable
// rsp      out        rsp_valid/rsp_stall  level, charger state, update and charge-mark flags
// csr      in         csr_valid/csr_ready  register index, write data
//
// A request is taken only in ST_IDLE, so a new one is not accepted until the previous result
// has been committed to the output register; the percentage divider is a restoring one that
// resolves one quotient bit per cycle, and the sample average is a reciprocal multiply.
// A finished result sits in the output register; the next request is taken meanwhile and
// its result waits for that register to drain.
// Synchronous reset restores register defaults and clears display state; csr is always ready.
module battery_level_gauge_unit
   import blg_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_a,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_b,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_c,
   input  logic                    req_adapter_present,
   input  logic [PINS_BITS-1:0]    req_charge_pin_samples,
   input  logic                    req_display_enable,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LEVEL_BITS-1:0]   rsp_level,
   output logic [CHG_BITS-1:0]     rsp_charger_state,
   output logic                    rsp_show_update,
   output logic                    rsp_show_charge_mark,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata
);

   // (avg - empty) * 100 needs 7 bits above the sample width
   localparam int unsigned DIV_BITS = SAMPLE_BITS + 7;

   cmd_type cmd;
   sts_type sts;

   blg_ctrl #(
      .DIV_BITS (DIV_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   blg_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DIV_BITS    (DIV_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_battery_sample_a   (req_battery_sample_a),
      .req_battery_sample_b   (req_battery_sample_b),
      .req_battery_sample_c   (req_battery_sample_c),
      .req_adapter_present    (req_adapter_present),
      .req_charge_pin_samples (req_charge_pin_samples),
      .req_display_enable     (req_display_enable),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_level              (rsp_level),
      .rsp_charger_state      (rsp_charger_state),
      .rsp_show_update        (rsp_show_update),
      .rsp_show_charge_mark   (rsp_show_charge_mark)
   );

endmodule

// ===== hw/rtl/blg_ctrl.sv =====
module blg_ctrl
   import blg_pkg::*;
#(
   parameter int unsigned DIV_BITS = 19
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int unsigned CNT_BITS = $clog2(DIV_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_BITS - 1);

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            cmd.latch_avg = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_pct = 1'b1;
            cnt_in       = '0;
            state_in     = ST_PCT;
         end
         ST_PCT: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("result committed while output register occupied");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PCT) |-> cnt_ff <= CNT_LAST)
      else $error("divider step count out of range");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_LATCH)
      else $error("accepted transaction did not start averaging");

endmodule

// ===== hw/rtl/blg_datapath.sv =====
module blg_datapath
   import blg_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 12,
   parameter int unsigned DIV_BITS    = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_a,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_b,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_c,
   input  logic                    req_adapter_present,
   input  logic [PINS_BITS-1:0]    req_charge_pin_samples,
   input  logic                    req_display_enable,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LEVEL_BITS-1:0]   rsp_level,
   output logic [CHG_BITS-1:0]     rsp_charger_state,
   output logic                    rsp_show_update,
   output logic                    rsp_show_charge_mark
);

   localparam int unsigned SUM_BITS    = SAMPLE_BITS + 2;
   // sum / 3 as (sum * ceil(2^k / 3)) >> k, exact for every sum below 2^(k-1)
   localparam int unsigned RECIP_SHIFT = SUM_BITS + 1;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / AVG_DIVISOR + 1;
   localparam int unsigned PROD_BITS   = 2 * SUM_BITS;

   // configuration
   logic [CFG_BITS-1:0]     empty_ff, full_ff, chg_full_ff;
   logic [HOLDOFF_BITS-1:0] holdoff_cfg_ff;

   // latched request
   logic                 adapter_ff;
   logic                 disp_ff;
   logic [PINS_BITS-1:0] pins_ff;
   logic [SAMPLE_BITS-1:0] avg_ff;

   // restoring divider
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [CFG_BITS-1:0] rem_ff, rem_in;
   logic [CFG_BITS-1:0] dvs_ff, dvs_in;

   // display state
   logic [LEVEL_BITS-1:0]   last_ff, last_in;
   logic [HOLDOFF_BITS-1:0] hc_ff, hc_in;

   // output register
   logic                  out_full_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic [CHG_BITS-1:0]   chg_ff;
   logic                  show_ff, mark_ff;

   logic [SUM_BITS-1:0] sum;
   logic [PROD_BITS-1:0] avg_prod;
   logic [CFG_BITS:0]   trial;
   logic                trial_ge;
   logic [CFG_BITS-1:0] top;
   logic [DIV_BITS-1:0] diff;
   logic                avg_gt_empty;
   logic                top_gt_empty;
   logic [LEVEL_BITS-1:0] pct;
   logic [CHG_BITS-1:0]   chg;
   logic [LEVEL_BITS-1:0] level;
   logic                  eligible;
   logic                  show, mark;
   logic                  rsp_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff       <= EMPTY_LEVEL_RST;
         full_ff        <= FULL_LEVEL_RST;
         chg_full_ff    <= CHARGE_FULL_LEVEL_RST;
         holdoff_cfg_ff <= DISPLAY_HOLDOFF_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EMPTY_LEVEL:       empty_ff       <= csr_wdata;
            CSR_FULL_LEVEL:        full_ff        <= csr_wdata;
            CSR_CHARGE_FULL_LEVEL: chg_full_ff    <= csr_wdata;
            CSR_DISPLAY_HOLDOFF:   holdoff_cfg_ff <= csr_wdata[HOLDOFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign sum = SUM_BITS'(req_battery_sample_a) + SUM_BITS'(req_battery_sample_b)
              + SUM_BITS'(req_battery_sample_c);

   // the sum sits in the quotient register until the average is latched
   assign avg_prod = PROD_BITS'(quo_ff[SUM_BITS-1:0]) * PROD_BITS'(RECIP);

   assign top          = adapter_ff ? chg_full_ff : full_ff;
   assign top_gt_empty = top > empty_ff;
   assign avg_gt_empty = DIV_BITS'(avg_ff) > DIV_BITS'(empty_ff);
   assign diff         = DIV_BITS'(avg_ff) - DIV_BITS'(empty_ff);

   assign trial    = {rem_ff, quo_ff[DIV_BITS-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (cmd.load) begin
         quo_in = DIV_BITS'(sum);
         rem_in = '0;
      end else if (cmd.load_pct) begin
         // below the empty level or with no span the quotient is not used
         quo_in = DIV_BITS'(diff * DIV_BITS'(LEVEL_FULL));
         rem_in = '0;
         dvs_in = top - empty_ff;
      end else if (cmd.step) begin
         quo_in = {quo_ff[DIV_BITS-2:0], trial_ge};
         rem_in = trial_ge ? CFG_BITS'(trial - {1'b0, dvs_ff}) : trial[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (cmd.load) begin
         adapter_ff <= req_adapter_present;
         disp_ff    <= req_display_enable;
         pins_ff    <= req_charge_pin_samples;
      end
      if (cmd.latch_avg) begin
         avg_ff <= avg_prod[RECIP_SHIFT +: SAMPLE_BITS];
      end
   end

   always_comb begin
      if (!avg_gt_empty) begin
         pct = LEVEL_ZERO;
      end else if (!top_gt_empty) begin
         pct = LEVEL_FULL;
      end else if (quo_ff > DIV_BITS'(LEVEL_FULL)) begin
         pct = LEVEL_FULL;
      end else begin
         pct = quo_ff[LEVEL_BITS-1:0];
      end

      chg = adapter_ff ? classify_pins(pins_ff) : CHG_DONE;

      if (!adapter_ff) begin
         level = pct;
      end else begin
         case (chg)
            CHG_ERROR:    level = LEVEL_NO_BATTERY;
            CHG_DONE:     level = avg_gt_empty ? LEVEL_FULL : LEVEL_NO_BATTERY;
            CHG_CHARGING: level = pct;
            default:      level = LEVEL_NO_BATTERY;
         endcase
      end
      eligible = !adapter_ff || (level <= LEVEL_FULL);

      last_in = last_ff;
      hc_in   = hc_ff;
      show    = 1'b0;
      mark    = 1'b0;
      if (!disp_ff) begin
         last_in = LEVEL_ZERO;
      end else if (eligible && (last_ff != level)) begin
         if (hc_ff == holdoff_cfg_ff) begin
            last_in = level;
            hc_in   = '0;
            show    = 1'b1;
            mark    = adapter_ff;
         end else begin
            hc_in = hc_ff + 1'b1;
         end
      end
   end

   assign rsp_take     = out_full_ff && !rsp_stall;
   assign sts.out_free = !out_full_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= LEVEL_ZERO;
         hc_ff       <= '0;
         out_full_ff <= 1'b0;
      end else if (cmd.commit) begin
         last_ff     <= last_in;
         hc_ff       <= hc_in;
         out_full_ff <= 1'b1;
      end else if (rsp_take) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         level_ff <= level;
         chg_ff   <= chg;
         show_ff  <= show;
         mark_ff  <= mark;
      end
   end

   assign rsp_valid            = out_full_ff;
   assign rsp_level            = level_ff;
   assign rsp_charger_state    = chg_ff;
   assign rsp_show_update      = show_ff;
   assign rsp_show_charge_mark = mark_ff;

   assert property (@(posedge clock) disable iff (reset)
      out_full_ff |-> (level_ff <= LEVEL_NO_BATTERY) && (show_ff || !mark_ff))
      else $error("inconsistent result in output register");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && show |=> last_ff == level_ff && hc_ff == '0)
      else $error("display state not updated with shown level");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable({rsp_level, rsp_charger_state, rsp_show_update, rsp_show_charge_mark}))
      else $error("stalled result changed or dropped");

endmodule

// ===== bench/battery_level_gauge_checker.sv =====
module battery_level_gauge_checker
   import blg_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_a,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_b,
   input  logic [SAMPLE_BITS-1:0]  req_battery_sample_c,
   input  logic                    req_adapter_present,
   input  logic [PINS_BITS-1:0]    req_charge_pin_samples,
   input  logic                    req_display_enable,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [LEVEL_BITS-1:0]   rsp_level,
   input  logic [CHG_BITS-1:0]     rsp_charger_state,
   input  logic                    rsp_show_update,
   input  logic                    rsp_show_charge_mark,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wdata,
   output int unsigned             failures,
   output int unsigned             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PERCENT_SCALE = 100;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [CHG_BITS-1:0]   charger_state;
      logic                  show_update;
      logic                  show_charge_mark;
   } gauge_reading_type;

   gauge_reading_type expected_readings[$];
   gauge_reading_type predicted;
   gauge_reading_type wanted;

   logic [CFG_BITS-1:0]     empty_lvl;
   logic [CFG_BITS-1:0]     full_lvl;
   logic [CFG_BITS-1:0]     charge_full_lvl;
   logic [HOLDOFF_BITS-1:0] holdoff_limit;
   logic [LEVEL_BITS-1:0]   shown_level;
   logic [HOLDOFF_BITS-1:0] holdoff_cnt;
   int unsigned             result_count;

   initial begin
      failures    = 0;
      outstanding = 0;
      result_count = 0;
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      failures++;
   endtask

   function automatic logic [LEVEL_BITS-1:0] span_percent(input int unsigned avg,
                                                          input int unsigned top,
                                                          input int unsigned zero_point);
      int unsigned q;
      if (avg <= zero_point) begin
         return LEVEL_ZERO;
      end
      // collapsed or inverted span saturates
      if (top <= zero_point) begin
         return LEVEL_FULL;
      end
      q = ((avg - zero_point) * PERCENT_SCALE) / (top - zero_point);
      return (q > PERCENT_SCALE) ? LEVEL_FULL : LEVEL_BITS'(q);
   endfunction

   task automatic predict_reading(output gauge_reading_type r);
      int unsigned           sum;
      int unsigned           avg;
      logic [3:0]            round0;
      logic [3:0]            round1;
      logic [LEVEL_BITS-1:0] lvl;
      logic                  eligible;
      logic                  hit;
      sum = 32'(req_battery_sample_a) + 32'(req_battery_sample_b)
          + 32'(req_battery_sample_c);
      avg = sum / 32'(AVG_DIVISOR);
      r.charger_state    = CHG_DONE;
      r.show_update      = 1'b0;
      r.show_charge_mark = 1'b0;
      if (!req_display_enable) begin
         shown_level = LEVEL_ZERO;
      end
      if (!req_adapter_present) begin
         lvl      = span_percent(avg, 32'(full_lvl), 32'(empty_lvl));
         eligible = 1'b1;
      end else begin
         round0 = req_charge_pin_samples[3:0];
         round1 = req_charge_pin_samples[7:4];
         // round 2 only contributes its first sample
         if (!((round0 == 4'h0 || round0 == 4'hF) && (round1 == 4'h0 || round1 == 4'hF))) begin
            r.charger_state = CHG_ERROR;
         end else begin
            r.charger_state = req_charge_pin_samples[8] ? CHG_DONE : CHG_CHARGING;
         end
         case (r.charger_state)
            CHG_ERROR: lvl = LEVEL_NO_BATTERY;
            CHG_DONE:  lvl = (avg > 32'(empty_lvl)) ? LEVEL_FULL : LEVEL_NO_BATTERY;
            default:   lvl = span_percent(avg, 32'(charge_full_lvl), 32'(empty_lvl));
         endcase
         eligible = (lvl <= LEVEL_FULL);
      end
      if (req_display_enable && eligible && shown_level != lvl) begin
         hit         = (holdoff_cnt == holdoff_limit);
         holdoff_cnt = holdoff_cnt + 1'b1;
         if (hit) begin
            shown_level        = lvl;
            holdoff_cnt        = '0;
            r.show_update      = 1'b1;
            r.show_charge_mark = req_adapter_present;
         end
      end
      r.level = lvl;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         empty_lvl       = EMPTY_LEVEL_RST;
         full_lvl        = FULL_LEVEL_RST;
         charge_full_lvl = CHARGE_FULL_LEVEL_RST;
         holdoff_limit   = DISPLAY_HOLDOFF_RST;
         shown_level     = LEVEL_ZERO;
         holdoff_cnt     = '0;
         expected_readings.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               report_error($sformatf("result %0d arrived with no transaction pending",
                                      result_count));
            end else begin
               wanted = expected_readings.pop_front();
               if (rsp_level !== wanted.level) begin
                  report_error($sformatf("result %0d: level got %0d expected %0d",
                                         result_count, rsp_level, wanted.level));
               end
               if (rsp_charger_state !== wanted.charger_state) begin
                  report_error($sformatf("result %0d: charger_state got %0d expected %0d",
                                         result_count, rsp_charger_state,
                                         wanted.charger_state));
               end
               if (rsp_show_update !== wanted.show_update) begin
                  report_error($sformatf("result %0d: show_update got %0b expected %0b",
                                         result_count, rsp_show_update, wanted.show_update));
               end
               if (rsp_show_charge_mark !== wanted.show_charge_mark) begin
                  report_error($sformatf("result %0d: show_charge_mark got %0b expected %0b",
                                         result_count, rsp_show_charge_mark,
                                         wanted.show_charge_mark));
               end
            end
            result_count++;
         end
         if (req_valid && !req_stall) begin
            predict_reading(predicted);
            expected_readings.push_back(predicted);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EMPTY_LEVEL:       empty_lvl       = csr_wdata;
               CSR_FULL_LEVEL:        full_lvl        = csr_wdata;
               CSR_CHARGE_FULL_LEVEL: charge_full_lvl = csr_wdata;
               CSR_DISPLAY_HOLDOFF:   holdoff_limit   = csr_wdata[HOLDOFF_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_readings.size();
   end

endmodule

// ===== bench/battery_level_gauge_unit_test.sv =====
module battery_level_gauge_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import blg_pkg::*;

   localparam int unsigned SAMPLE_BITS = 12;
   localparam int          SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [SAMPLE_BITS-1:0] sample_c;
      logic                   adapter;
      logic [PINS_BITS-1:0]   pins;
      logic                   disp;
   } gauge_request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SAMPLE_BITS-1:0]  req_battery_sample_a = '0;
   logic [SAMPLE_BITS-1:0]  req_battery_sample_b = '0;
   logic [SAMPLE_BITS-1:0]  req_battery_sample_c = '0;
   logic                    req_adapter_present = 1'b0;
   logic [PINS_BITS-1:0]    req_charge_pin_samples = '0;
   logic                    req_display_enable = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [LEVEL_BITS-1:0]   rsp_level;
   logic [CHG_BITS-1:0]     rsp_charger_state;
   logic                    rsp_show_update;
   logic                    rsp_show_charge_mark;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_EMPTY_LEVEL;
   logic [CFG_BITS-1:0]     csr_wdata = '0;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_off = 1'b0;
   int          cfg_empty = int'(EMPTY_LEVEL_RST);
   int          cfg_full = int'(FULL_LEVEL_RST);
   int          cfg_charge = int'(CHARGE_FULL_LEVEL_RST);

   battery_level_gauge_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

   battery_level_gauge_checker #(.SAMPLE_BITS(SAMPLE_BITS)) checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("battery_level_gauge_unit regression: fail");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (idle_off) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left == 0 && !idle_off) begin
         stall_left = pick_gap();
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   function automatic gauge_request_type make_req(input int a, input int b, input int c,
                                                  input bit adapter, input int pins,
                                                  input bit disp);
      gauge_request_type r;
      r.sample_a = SAMPLE_BITS'(a);
      r.sample_b = SAMPLE_BITS'(b);
      r.sample_c = SAMPLE_BITS'(c);
      r.adapter  = adapter;
      r.pins     = PINS_BITS'(pins);
      r.disp     = disp;
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] near_sample(input int base);
      int v;
      v = base + int'($urandom_range(0, 16)) - 8;
      if (v < 0) begin
         v = 0;
      end
      if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
      end
      return SAMPLE_BITS'(v);
   endfunction

   function automatic gauge_request_type random_request();
      gauge_request_type r;
      int                base;
      int                lo;
      int                hi;
      int unsigned       roll;
      lo   = cfg_empty;
      hi   = (cfg_full > cfg_charge) ? cfg_full : cfg_charge;
      roll = $urandom_range(0, 99);
      // mostly around the configured span so the percentage math gets exercised
      if (roll < 60) begin
         base = $urandom_range((lo > 64) ? lo - 64 : 0,
                               (hi + 64 > SAMPLE_MAX) ? SAMPLE_MAX : hi + 64);
      end else if (roll < 85) begin
         base = $urandom_range(0, SAMPLE_MAX);
      end else begin
         base = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         r.sample_a = SAMPLE_BITS'($urandom);
         r.sample_b = SAMPLE_BITS'($urandom);
         r.sample_c = SAMPLE_BITS'($urandom);
      end else begin
         r.sample_a = near_sample(base);
         r.sample_b = near_sample(base);
         r.sample_c = near_sample(base);
      end
      r.adapter = 1'($urandom_range(0, 1));
      r.pins    = PINS_BITS'($urandom);
      if ($urandom_range(0, 99) < 70) begin
         r.pins[3:0] = $urandom_range(0, 1) ? 4'hF : 4'h0;
         r.pins[7:4] = $urandom_range(0, 1) ? 4'hF : 4'h0;
      end
      r.disp = ($urandom_range(0, 9) != 0);
      return r;
   endfunction

   task automatic send_item(input gauge_request_type r);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_battery_sample_a   <= r.sample_a;
      req_battery_sample_b   <= r.sample_b;
      req_battery_sample_c   <= r.sample_c;
      req_adapter_present    <= r.adapter;
      req_charge_pin_samples <= r.pins;
      req_display_enable     <= r.disp;
      do @(posedge clock); while (req_stall);
   endtask

   // hold the sender until every transaction has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_BITS'(data);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input int e, input int f, input int cf, input int h);
      write_csr(CSR_EMPTY_LEVEL, e);
      write_csr(CSR_FULL_LEVEL, f);
      write_csr(CSR_CHARGE_FULL_LEVEL, cf);
      write_csr(CSR_DISPLAY_HOLDOFF, h);
      @(negedge clock);
      csr_valid  <= 1'b0;
      cfg_empty  = e;
      cfg_full   = f;
      cfg_charge = cf;
   endtask

   task automatic run_phase(input int e, input int f, input int cf, input int h,
                            input int unsigned count, input bit quiet);
      drain();
      configure(e, f, cf, h);
      idle_off = quiet;
      repeat (count) send_item(random_request());
      idle_off = 1'b0;
   endtask

   initial begin
      int e;
      int f;
      int cf;
      int h;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values
      send_item(make_req(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 12'h000, 1'b1));
      send_item(make_req(0, 0, 0, 1'b0, 12'h000, 1'b1));
      send_item(make_req(3000, 3000, 3000, 1'b1, 12'h000, 1'b1));

      drain();
      configure(int'(EMPTY_LEVEL_RST), int'(FULL_LEVEL_RST), int'(CHARGE_FULL_LEVEL_RST), 0);
      send_item(make_req(2560, 2560, 2561, 1'b0, 12'h0F0, 1'b1));
      send_item(make_req(2048, 2048, 2048, 1'b0, 12'h000, 1'b1));
      send_item(make_req(2049, 2049, 2049, 1'b0, 12'h000, 1'b1));
      send_item(make_req(3000, 3000, 3000, 1'b1, 12'h100, 1'b1));  // done
      send_item(make_req(1000, 1000, 1000, 1'b1, 12'h1FF, 1'b1));  // done, battery low
      send_item(make_req(3000, 3000, 3000, 1'b1, 12'h005, 1'b1));  // round 0 unsteady
      send_item(make_req(3000, 3000, 3000, 1'b1, 12'h0A0, 1'b1));  // round 1 unsteady
      send_item(make_req(2700, 2700, 2700, 1'b1, 12'hE0F, 1'b1));  // round 2 mismatch
      send_item(make_req(2700, 2700, 2700, 1'b1, 12'hDFF, 1'b1));  // round 2 mismatch, done
      send_item(make_req(3200, 3200, 3200, 1'b1, 12'h000, 1'b1));
      send_item(make_req(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1, 12'h0FF, 1'b1));
      send_item(make_req(2560, 2560, 2560, 1'b0, 12'hFFF, 1'b0));
      send_item(make_req(2600, 2600, 2600, 1'b1, 12'h000, 1'b0));
      send_item(make_req(2560, 2560, 2560, 1'b0, 12'h000, 1'b1));
      send_item(make_req(2560, 2560, 2560, 1'b0, 12'h000, 1'b1));  // same level again
      send_item(make_req(0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 12'h000, 1'b1));
      send_item(make_req(2900, 2900, 2900, 1'b1, 12'hFFF, 1'b1));

      // an inverted full span and a collapsed charge span
      drain();
      configure(3000, 1000, 3000, 1);
      send_item(make_req(3500, 3500, 3500, 1'b0, 12'h000, 1'b1));
      send_item(make_req(3000, 3000, 3000, 1'b0, 12'h000, 1'b1));
      send_item(make_req(3500, 3500, 3500, 1'b1, 12'h000, 1'b1));
      send_item(make_req(3600, 3600, 3600, 1'b1, 12'h000, 1'b1));

      run_phase(0, SAMPLE_MAX, SAMPLE_MAX, 0, 150, 1'b0);
      run_phase(SAMPLE_MAX, 0, 0, 1, 60, 1'b0);
      run_phase(3000, 1000, 2500, 2, 150, 1'b0);
      // long hold-off, then a short one so the counter has to wrap
      run_phase(1000, 3000, 3500, 127, 150, 1'b1);
      run_phase(1500, 3200, 3400, 3, 150, 1'b0);
      run_phase(int'(EMPTY_LEVEL_RST), int'(FULL_LEVEL_RST), int'(CHARGE_FULL_LEVEL_RST),
                int'(DISPLAY_HOLDOFF_RST), 100, 1'b0);
      for (int p = 0; p < 6; p++) begin
         e  = $urandom_range(0, 3800);
         f  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, SAMPLE_MAX))
                                          : e + int'($urandom_range(1, 1500));
         cf = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, SAMPLE_MAX))
                                          : e + int'($urandom_range(1, 1500));
         if (f > SAMPLE_MAX) begin
            f = SAMPLE_MAX;
         end
         if (cf > SAMPLE_MAX) begin
            cf = SAMPLE_MAX;
         end
         h = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 127))
                                         : int'($urandom_range(0, 4));
         run_phase(e, f, cf, h, 170, p == 4);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("battery_level_gauge_unit regression: pass");
      end else begin
         $display("battery_level_gauge_unit regression: fail");
      end
      $finish;
   end

endmodule
